### hdl/tds_pkg.sv
`default_nettype none

package tds_pkg;

  // Number of release outputs in the row.
  localparam int unsigned OutputCount = 2;
  // next_index runs 0..OutputCount, so it needs one code beyond the last output.
  localparam int unsigned IdxW   = $clog2(OutputCount + 1);
  localparam int unsigned TicksW = 16;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_DROP   = 2'd1,
    FN_RELOAD = 2'd2,
    FN_KILL   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_TIMING = 3'd1,
    ERR_ALL_FIRED = 3'd2,
    ERR_KILL      = 3'd3,
    ERR_NOT_ARMED = 3'd4,
    ERR_BUSY      = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    ST_ERROR    = 2'd0,
    ST_DISARMED = 2'd1,
    ST_DROPPING = 2'd2,
    ST_READY    = 2'd3
  } status_e;

  typedef struct packed {
    func_e func;
    logic  armed;
    logic  kill_asserted;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    err_e       error_code;
    logic [1:0] drive_levels;
    status_e    status;
    logic [1:0] available;
    logic       busy_res;
    logic       fault_raised;
  } result_t;

endpackage

`default_nettype wire

### hdl/tds_core.sv
`default_nettype none

module tds_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tds_pkg::TicksW-1:0]      cfg_data_i,
  input  logic                            cmd_en_i,
  input  tds_pkg::cmd_t                   cmd_i,
  output tds_pkg::result_t                res_o
);
  import tds_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(OutputCount);

  logic [TicksW-1:0]      pulse_ticks_q;
  logic [IdxW-1:0]        next_index_q, next_index_d;
  logic                   running_q, running_d;
  logic [TicksW-1:0]      ticks_left_q, ticks_left_d;
  logic [OutputCount-1:0] levels_q, levels_d;
  logic [TicksW-1:0]      ticks_dec;
  logic                   all_fired;
  logic                   acc;
  err_e                   err;
  logic                   fault;
  status_e                status;

  assign all_fired = (next_index_q >= LastIdx);
  assign ticks_dec = (ticks_left_q != '0) ? ticks_left_q - TicksW'(1) : '0;

  always_comb begin
    next_index_d = next_index_q;
    running_d    = running_q;
    ticks_left_d = ticks_left_q;
    levels_d     = levels_q;
    acc          = 1'b0;
    err          = ERR_NONE;
    fault        = 1'b0;
    unique case (cmd_i.func)
      FN_TICK: begin
        if (running_q) begin
          ticks_left_d = ticks_dec;
          if (ticks_dec == '0) begin
            // pulse done: release everything, advance to the next output
            levels_d     = '0;
            running_d    = 1'b0;
            if (!all_fired) next_index_d = next_index_q + IdxW'(1);
          end
        end
      end
      FN_DROP: begin
        priority if (pulse_ticks_q == '0) begin
          err = ERR_NO_TIMING;
        end else if (all_fired) begin
          err = ERR_ALL_FIRED;
        end else if (cmd_i.kill_asserted) begin
          err = ERR_KILL;
        end else if (!cmd_i.armed) begin
          err = ERR_NOT_ARMED;
        end else if (running_q) begin
          err = ERR_BUSY;
        end else begin
          levels_d     = levels_q | (OutputCount'(1) << next_index_q);
          running_d    = 1'b1;
          ticks_left_d = pulse_ticks_q;
          acc          = 1'b1;
        end
      end
      FN_RELOAD: begin
        if (running_q) begin
          err = ERR_BUSY;
        end else begin
          next_index_d = '0;
          acc          = 1'b1;
        end
      end
      FN_KILL: begin
        // outputs drop at once; timer keeps running to its end
        levels_d = '0;
        fault    = running_q;
      end
      default: ;
    endcase

    priority if (pulse_ticks_q == '0) status = ST_ERROR;
    else if (!cmd_i.armed)            status = ST_DISARMED;
    else if (running_d)               status = ST_DROPPING;
    else                              status = ST_READY;

    res_o.accepted     = acc;
    res_o.error_code   = err;
    res_o.drive_levels = 2'(levels_d);
    res_o.status       = status;
    res_o.available    = 2'(LastIdx - next_index_d);
    res_o.busy_res     = running_d;
    res_o.fault_raised = fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q <= '0;
      next_index_q  <= '0;
      running_q     <= 1'b0;
      ticks_left_q  <= '0;
      levels_q      <= '0;
    end else begin
      if (cfg_we_i) pulse_ticks_q <= cfg_data_i;
      if (cmd_en_i) begin
        next_index_q <= next_index_d;
        running_q    <= running_d;
        ticks_left_q <= ticks_left_d;
        levels_q     <= levels_d;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/tds_out_fifo.sv
`default_nettype none

module tds_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tds_pkg::result_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output tds_pkg::result_t data_o
);
  import tds_pkg::*;

  // two entries: one result can wait while the next transaction is taken
  result_t    mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/timed_dropper_sequencer.sv
// Timed dropper sequencer: fires a row of release outputs one at a time.
// Input channel (in_valid_i / in_stall_o) carries one command transaction:
//   func_i (tick, drop, reload, kill), armed_i and kill_asserted_i.
// Output channel (out_valid_o / out_stall_i) returns exactly one result
//   transaction per command: accepted, error code, output levels, status,
//   outputs still available, busy and kill fault.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the pulse
//   length in millisecond ticks; always ready, write it only while idle.
// Results: a result is written into the result buffer when its command is
//   taken. Throughput: one command per cycle while the result buffer is not
//   full, with the state update done in the core as each command is taken.
// A two-entry result buffer sits on the output, so the input keeps taking
//   commands while one result waits; in_stall_o rises only when both
//   entries are held by a stalled receiver.
// Reset (rst_ni low, async) clears the pulse length (timing missing),
//   the firing index, the pulse timer, all outputs and the result buffer.
`default_nettype none

module timed_dropper_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // command in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic        armed_i,
  input  logic        kill_asserted_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [2:0]  error_code_o,
  output logic [1:0]  drive_levels_o,
  output logic [1:0]  status_o,
  output logic [1:0]  available_o,
  output logic        busy_res_o,
  output logic        fault_raised_o
);
  import tds_pkg::*;

  cmd_t    cmd;
  result_t core_res;
  result_t out_res;
  logic    fifo_full;
  logic    in_take;
  logic    out_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fifo_full;
  assign in_take     = in_valid_i && !fifo_full;
  assign out_take    = out_valid_o && !out_stall_i;

  assign cmd.func          = func_e'(func_i);
  assign cmd.armed         = armed_i;
  assign cmd.kill_asserted = kill_asserted_i;

  // state update and result in one pass
  tds_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_en_i   (in_take),
    .cmd_i      (cmd),
    .res_o      (core_res)
  );

  // result buffer decouples the two sides
  tds_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_take),
    .data_i  (core_res),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .pop_i   (out_take),
    .data_o  (out_res)
  );

  assign accepted_o     = out_res.accepted;
  assign error_code_o   = out_res.error_code;
  assign drive_levels_o = out_res.drive_levels;
  assign status_o       = out_res.status;
  assign available_o    = out_res.available;
  assign busy_res_o     = out_res.busy_res;
  assign fault_raised_o = out_res.fault_raised;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && busy_res_o) |-> (status_o != ST_READY))
    else $error("busy result reports ready status");

  a_accept_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (error_code_o == ERR_NONE))
    else $error("accepted result carries an error code");

  a_fault_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_raised_o) |-> (drive_levels_o == 2'b00 && busy_res_o))
    else $error("kill fault with outputs driven or no pulse running");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result buffer");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("taken transaction left no result");
`endif

endmodule

`default_nettype wire
